// File: sv/sstod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sstod_pkg;

  // Width of one temperature sample
  localparam int SAMPLE_BITS = 12;

  // Input tdata: rx_byte, then four samples, padded to whole bytes
  localparam int IN_FIELDS_W = 8 + 4 * SAMPLE_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;

  // Temperature conversion
  localparam int TEMP_GAIN   = 2475;
  localparam int TEMP_OFFSET = 1475;
  localparam int TEMP_MAX    = 99;

  // Receive mode of the serial command parser
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SET,
    MODE_ECHO
  } rx_mode_t;

  // Kind of output job
  typedef enum logic [1:0] {
    JOB_ECHO,
    JOB_SET,
    JOB_TICK
  } job_kind_t;

  // One output job: up to eight prepared characters plus the sample average
  typedef struct packed {
    job_kind_t              kind;
    logic [7:0][7:0]        chars;
    logic [SAMPLE_BITS-1:0] avg;
  } job_t;

endpackage

`default_nettype wire

// File: sv/serial_set_time_of_day_clock_unit.sv
// Serial-set hours:minutes:seconds clock with temperature report.
// Input stream: one transaction per received serial byte (in_tuser = 0) or
// per one-second tick (in_tuser = 1, four temperature samples in in_tdata).
// Output stream: ASCII characters for the serial line; out_tlast marks the
// final character caused by one input transaction.
// A tick sends HH:MM:SS as it was before the increment, then two temperature
// digits (ten characters). '$' plus eight bytes echoes the eight bytes and
// loads the time when they are valid; '#' echoes nonzero bytes until '*'.
// The front parser takes one transaction per cycle while the queue has room
// and pushes output jobs into a two-entry job queue; the back emitter sends
// one character per cycle unless the receiver stalls; it bounds throughput.
// The first character of a job passes the queue, job register and output
// register. Jobs hold ten characters per tick, eight per set, one per echo.
// When the receiver stalls, the output register holds its character, the
// queue fills and in_tready drops once both job entries are taken.
// Synchronous reset clears the time to 00:00:00, the parser to idle and
// empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module serial_set_time_of_day_clock_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // rx_byte[7:0], adc_sample_0, adc_sample_1, adc_sample_2, adc_sample_3
  input  logic [sstod_pkg::IN_DATA_W-1:0] in_tdata,
  // func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_byte[7:0]
  output logic [7:0]                      out_tdata,
  output logic                            out_tlast
);
  import sstod_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t push_job, head_job;

  sstod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  sstod_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_job (head_job)
  );

  sstod_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: sv/sstod_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sstod_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sstod_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                            in_tuser,
  input  logic                            q_full,
  output logic                            q_push,
  output sstod_pkg::job_t                 q_job
);
  import sstod_pkg::*;

  // Two ASCII digits of a value below 64, tens digit in the upper byte
  function automatic logic [15:0] ascii2(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] rem;
    tens = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(10 * k)) begin
        tens = 3'(k);
      end
    end
    rem = v - 6'({3'd0, tens} * 6'd10);
    return {CH_ZERO + {5'd0, tens}, CH_ZERO + {4'd0, rem[3:0]}};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [6:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
    return 7'({3'd0, hi[3:0]} * 7'd10) + {3'd0, lo[3:0]};
  endfunction

  rx_mode_t   rx_mode_r, rx_mode_nxt;
  logic [2:0] set_count_r, set_count_nxt;
  logic [7:0] set_chars_r [7];
  logic [7:0] set_chars_nxt [7];
  logic [4:0] hours_r, hours_nxt;
  logic [5:0] minutes_r, minutes_nxt;
  logic [5:0] seconds_r, seconds_nxt;

  logic                   acc;
  logic [7:0]             rx_byte;
  logic [SAMPLE_BITS+1:0] sum;
  logic [7:0][7:0]        set_all;
  logic                   set_ok;
  logic [6:0]             set_h, set_m, set_s;
  logic [15:0]            h_asc, m_asc, s_asc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign rx_byte   = in_tdata[7:0];

  // Sum the four samples
  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      sum = sum + {2'b00, in_tdata[8 + k * SAMPLE_BITS +: SAMPLE_BITS]};
    end
  end

  // Assemble and check the eight set characters
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      set_all[k] = set_chars_r[k];
    end
    set_all[7] = rx_byte;
    set_h  = pair_val(set_all[0], set_all[1]);
    set_m  = pair_val(set_all[3], set_all[4]);
    set_s  = pair_val(set_all[6], set_all[7]);
    set_ok = is_digit(set_all[0]) && is_digit(set_all[1]) &&
             is_digit(set_all[3]) && is_digit(set_all[4]) &&
             is_digit(set_all[6]) && is_digit(set_all[7]) &&
             (set_h < 7'd24) && (set_m < 7'd60) && (set_s < 7'd60);
  end

  assign h_asc = ascii2({1'b0, hours_r});
  assign m_asc = ascii2(minutes_r);
  assign s_asc = ascii2(seconds_r);

  // Classify the transaction, update parser and clock, build the job
  always_comb begin
    rx_mode_nxt   = rx_mode_r;
    set_count_nxt = set_count_r;
    set_chars_nxt = set_chars_r;
    hours_nxt     = hours_r;
    minutes_nxt   = minutes_r;
    seconds_nxt   = seconds_r;
    q_push        = 1'b0;
    q_job.kind    = JOB_ECHO;
    q_job.chars   = '0;
    q_job.avg     = sum[SAMPLE_BITS+1:2];
    if (acc) begin
      if (in_tuser) begin
        q_push         = 1'b1;
        q_job.kind     = JOB_TICK;
        q_job.chars[0] = h_asc[15:8];
        q_job.chars[1] = h_asc[7:0];
        q_job.chars[2] = CH_COLON;
        q_job.chars[3] = m_asc[15:8];
        q_job.chars[4] = m_asc[7:0];
        q_job.chars[5] = CH_COLON;
        q_job.chars[6] = s_asc[15:8];
        q_job.chars[7] = s_asc[7:0];
        // Advance the clock with carries
        if (seconds_r >= 6'd59) begin
          seconds_nxt = 6'd0;
          if (minutes_r >= 6'd59) begin
            minutes_nxt = 6'd0;
            hours_nxt   = (hours_r >= 5'd23) ? 5'd0 : hours_r + 5'd1;
          end else begin
            minutes_nxt = minutes_r + 6'd1;
          end
        end else begin
          seconds_nxt = seconds_r + 6'd1;
        end
      end else begin
        unique case (rx_mode_r)
          MODE_SET: begin
            if (set_count_r != 3'd7) begin
              set_chars_nxt[set_count_r] = rx_byte;
              set_count_nxt              = set_count_r + 3'd1;
            end else begin
              q_push        = 1'b1;
              q_job.kind    = JOB_SET;
              q_job.chars   = set_all;
              set_count_nxt = 3'd0;
              rx_mode_nxt   = MODE_IDLE;
              if (set_ok) begin
                hours_nxt   = set_h[4:0];
                minutes_nxt = set_m[5:0];
                seconds_nxt = set_s[5:0];
              end
            end
          end
          MODE_ECHO: begin
            if (rx_byte == CH_STAR) begin
              rx_mode_nxt = MODE_IDLE;
            end else if (rx_byte != 8'd0) begin
              q_push         = 1'b1;
              q_job.kind     = JOB_ECHO;
              q_job.chars[0] = rx_byte;
            end
          end
          default: begin
            if (rx_byte == CH_DOLLAR) begin
              rx_mode_nxt   = MODE_SET;
              set_count_nxt = 3'd0;
            end else if (rx_byte == CH_HASH) begin
              rx_mode_nxt = MODE_ECHO;
            end else begin
              rx_mode_nxt = MODE_IDLE;
            end
          end
        endcase
      end
    end
  end

  // Hold parser and time of day
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_mode_r   <= MODE_IDLE;
      set_count_r <= 3'd0;
      hours_r     <= 5'd0;
      minutes_r   <= 6'd0;
      seconds_r   <= 6'd0;
    end else begin
      rx_mode_r   <= rx_mode_nxt;
      set_count_r <= set_count_nxt;
      hours_r     <= hours_nxt;
      minutes_r   <= minutes_nxt;
      seconds_r   <= seconds_nxt;
    end
  end

  // Collected set characters
  always_ff @(posedge clk) begin
    set_chars_r <= set_chars_nxt;
  end

endmodule

`default_nettype wire

// File: sv/sstod_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sstod_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sstod_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output sstod_pkg::job_t head_job
);
  import sstod_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign head_job = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: sv/sstod_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sstod_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  sstod_pkg::job_t q_job,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);
  import sstod_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + 12;

  logic              job_valid_r;
  job_t              job_r;
  logic [3:0]        idx_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic [PROD_W-1:0] prod_r;
  logic [6:0]        temp_r;
  logic [3:0]        temp_hi_r, temp_lo_r;

  logic [3:0]  last_idx;
  logic [7:0]  cur_char;
  logic        adv, done;
  logic [11:0] q_scaled;
  logic [11:0] dpos;
  logic [26:0] quo_m;
  logic [7:0]  quo;
  logic [6:0]  temp_nxt;
  logic [14:0] tens_m;
  logic [6:0]  units_w;

  // Last character index per job kind
  always_comb begin
    unique case (job_r.kind)
      JOB_TICK: last_idx = 4'd9;
      JOB_SET:  last_idx = 4'd7;
      default:  last_idx = 4'd0;
    endcase
  end

  // Select the character for the current position
  always_comb begin
    if (idx_r < 4'd8) begin
      cur_char = job_r.chars[idx_r[2:0]];
    end else if (idx_r == 4'd8) begin
      cur_char = CH_ZERO + {4'd0, temp_hi_r};
    end else begin
      cur_char = CH_ZERO + {4'd0, temp_lo_r};
    end
  end

  assign adv   = job_valid_r && (!out_valid_r || out_tready);
  assign done  = adv && (idx_r == last_idx);
  assign q_pop = q_valid && (!job_valid_r || done);

  // Temperature: scale, clamp at zero, divide by ten, saturate
  always_comb begin
    q_scaled = prod_r[PROD_W-1:SAMPLE_BITS];
    dpos     = 12'(TEMP_OFFSET) - q_scaled;
    quo_m    = 27'(dpos[10:0]) * 27'd52429;
    quo      = quo_m[26:19];
    if (q_scaled > 12'(TEMP_OFFSET)) begin
      temp_nxt = 7'd0;
    end else if (quo > 8'(TEMP_MAX)) begin
      temp_nxt = 7'(TEMP_MAX);
    end else begin
      temp_nxt = quo[6:0];
    end
    tens_m  = 15'(temp_r) * 15'd205;
    units_w = temp_r - 7'({3'd0, tens_m[14:11]} * 7'd10);
  end

  // Job and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        job_valid_r <= 1'b1;
        idx_r       <= 4'd0;
      end else if (done) begin
        job_valid_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  // Payload and temperature pipeline
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= q_job;
      prod_r <= PROD_W'(q_job.avg) * PROD_W'(TEMP_GAIN);
    end
    if (adv) begin
      out_byte_r <= cur_char;
      out_last_r <= (idx_r == last_idx);
    end
    temp_r    <= temp_nxt;
    temp_hi_r <= tens_m[14:11];
    temp_lo_r <= units_w[3:0];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
